/* src/vtem_pkg.sv */
// ----------------------------------------------------------------------------
// vtem_pkg
// shared types and constants of the threshold and erosion mask block
// ----------------------------------------------------------------------------
package vtem_pkg;

  localparam int AXIS_W      = 7;
  localparam int AXIS_MAX    = 64;
  localparam int POS_W       = 6;
  localparam int SXY_W       = 13;
  localparam int CNT_MIN_W   = 19;
  localparam int FRAC_W      = 16;
  localparam int PASS_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 8;

  localparam int DEF_MAX_VOXELS = 262144;
  localparam int DEF_VOXEL_BITS = 16;
  // erosion box radius, the neighbor sweep is built for one voxel each way
  localparam int ERODE_RADIUS   = 1;

  localparam logic [AXIS_W-1:0] SIZE_RST = 7'd64;
  localparam logic [FRAC_W-1:0] FRAC_RST = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_FRAC   = 3'd3,
    CFG_PASSES = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_THR,
    ST_ER_RD,
    ST_ER_WR,
    ST_FRD,
    ST_FOUT
  } vtem_state_t;

  // extent clamp: 0 counts as 1, above 64 counts as 64
  function automatic logic [AXIS_W-1:0] axis_clamp(input logic [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] r;
    r = v;
    if (v == '0) r = AXIS_W'(1);
    else if (v > AXIS_W'(AXIS_MAX)) r = AXIS_W'(AXIS_MAX);
    return r;
  endfunction

endpackage

/* src/volume_threshold_erode_mask.sv */
// ----------------------------------------------------------------------------
// volume_threshold_erode_mask
// relative threshold mask of a loaded volume with 3x3x3 box erosion rounds
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tuser: action, tdata: voxel_value
//  out_    | master    | out_tvalid/out_tready| tdata: mask_bit, tlast: last_voxel
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_addr: register, cfg_data: value
//
// a load writes its voxel to the voxel memory on accept; a fetch of a built
// mask holds the input through accept, mask memory read and output register
// the first fetch after loading builds the mask: the threshold product, a
// threshold stream through the voxel memory, then erosion rounds over the
// 3x3x3 neighbors of each voxel, one neighbor read of the mask memory a cycle;
// the two mask memories swap roles each round
// reset is synchronous active low and clears control and config registers; the
// memories are not cleared and need no clearing pass
// a config write holds in_tready low while the volume size settles
// a fetch waits in the output state with in_tready low while a result is stalled
// ----------------------------------------------------------------------------
module volume_threshold_erode_mask #(
  parameter int MAX_VOXELS   = vtem_pkg::DEF_MAX_VOXELS,
  parameter int VOXEL_BITS   = vtem_pkg::DEF_VOXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [vtem_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] voxel_value
  input  logic [0:0]                          in_tuser,   // [0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [vtem_pkg::OUT_DATA_W-1:0]     out_tdata,  // [0] mask_bit, rest zero
  output logic                                out_tlast,  // last_voxel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vtem_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [vtem_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vtem_pkg::*;

  localparam int AW  = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
  localparam int IW  = (AW + 1 > CNT_MIN_W) ? AW + 1 : CNT_MIN_W;
  localparam int LW  = VOXEL_BITS + FRAC_W;
  localparam int OFW = 2;   // one neighbor offset counter, 0..2*radius
  localparam logic [IW-1:0] MAXV = IW'(MAX_VOXELS);
  localparam logic [OFW-1:0] OFMAX = OFW'(2 * ERODE_RADIUS);

  // memories
  logic [VOXEL_BITS-1:0] voxel_mem [MAX_VOXELS];
  logic                  mask_a    [MAX_VOXELS];
  logic                  mask_b    [MAX_VOXELS];

  // config registers
  logic [AXIS_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [FRAC_W-1:0] frac_r;
  logic [PASS_W-1:0] passes_r;
  logic [SXY_W-1:0]  sxy_r;
  logic [IW-1:0]     n_r;
  logic [1:0]        settle_r;
  logic [AXIS_W-1:0] ax, ay, az;

  // control state
  vtem_state_t state_r, state_nxt;
  logic [VOXEL_BITS-1:0] max_r;
  logic [IW-1:0]   load_cnt_r, fetch_cnt_r, thr_idx_r, cidx_r, p_idx_r;
  logic            ready_r, sel_r, p_v_r, nb_v_r, nb_rd_r, acc_r, hit_r, last_r;
  logic [LW-1:0]   limit_r;
  logic [PASS_W-1:0] pass_r;
  logic [POS_W-1:0]  x_r, y_r, z_r;
  logic [OFW-1:0]    dx_r, dy_r, dz_r;
  logic            out_valid_r, out_mask_r, out_last_r;

  // memory ports
  logic [VOXEL_BITS-1:0] vq_r;
  logic            qa_r, qb_r, mq;
  logic            v_re, m_re;
  logic [AW-1:0]   v_raddr, m_raddr;

  logic            in_acc, is_load, is_fetch;
  logic            nb_in, nb_mem, nb_bit, keep, ctr_last, ax_in, ay_in, az_in;
  logic [IW-1:0]   nidx, offx, offy, offz;
  logic [VOXEL_BITS-1:0] v_in;

  assign ax = axis_clamp(size_x_r);
  assign ay = axis_clamp(size_y_r);
  assign az = axis_clamp(size_z_r);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (settle_r == 2'd0);
  assign in_acc     = in_tvalid && in_tready;
  assign is_load    = in_acc && !in_tuser[0];
  assign is_fetch   = in_acc && in_tuser[0];
  assign v_in       = VOXEL_BITS'(in_tdata);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_mask_r);
  assign out_tlast  = out_last_r;
  assign mq         = sel_r ? qb_r : qa_r;

  // neighbor of the current center for the erosion sweep
  assign ax_in = !(x_r == '0 && dx_r == '0) && ({2'b0, x_r} + 8'(dx_r) <= {1'b0, ax});
  assign ay_in = !(y_r == '0 && dy_r == '0) && ({2'b0, y_r} + 8'(dy_r) <= {1'b0, ay});
  assign az_in = !(z_r == '0 && dz_r == '0) && ({2'b0, z_r} + 8'(dz_r) <= {1'b0, az});
  assign nb_in = ax_in && ay_in && az_in;
  assign offx  = (dx_r == '0) ? '1 : (dx_r == OFMAX) ? IW'(1) : '0;
  assign offy  = (dy_r == '0) ? (IW'(0) - IW'(ax)) : (dy_r == OFMAX) ? IW'(ax) : '0;
  assign offz  = (dz_r == '0) ? (IW'(0) - IW'(sxy_r)) : (dz_r == OFMAX) ? IW'(sxy_r) : '0;
  assign nidx  = cidx_r + offx + offy + offz;
  assign nb_mem = nidx < MAXV;
  // voxel outside the store reads as 0, outside the volume counts as 1
  assign nb_bit = nb_v_r ? (nb_rd_r && mq) : 1'b1;
  assign keep   = acc_r && nb_bit;
  assign ctr_last = (cidx_r + IW'(1) == n_r);

  // next state and memory read controls
  always_comb begin
    state_nxt = state_r;
    v_re      = 1'b0;
    v_raddr   = thr_idx_r[AW-1:0];
    m_re      = 1'b0;
    m_raddr   = fetch_cnt_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (is_fetch) begin
          state_nxt = ready_r ? ST_FRD : ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_THR;
      ST_THR: begin
        if (thr_idx_r < n_r) begin
          v_re = thr_idx_r < MAXV;
        end else if (!p_v_r) begin
          state_nxt = (passes_r == '0) ? ST_FRD : ST_ER_RD;
        end
      end
      ST_ER_RD: begin
        m_re    = nb_in && nb_mem;
        m_raddr = nidx[AW-1:0];
        if (dx_r == OFMAX && dy_r == OFMAX && dz_r == OFMAX) begin
          state_nxt = ST_ER_WR;
        end
      end
      ST_ER_WR: begin
        if (ctr_last && pass_r + PASS_W'(1) == passes_r) state_nxt = ST_FRD;
        else state_nxt = ST_ER_RD;
      end
      ST_FRD: begin
        m_re      = (fetch_cnt_r < n_r) && (fetch_cnt_r < MAXV);
        state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // config registers and volume size, two pipelined products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RST;
      size_y_r <= SIZE_RST;
      size_z_r <= SIZE_RST;
      frac_r   <= FRAC_RST;
      passes_r <= '0;
      sxy_r    <= SXY_W'(AXIS_MAX * AXIS_MAX);
      n_r      <= IW'(AXIS_MAX * AXIS_MAX * AXIS_MAX);
      settle_r <= '0;
    end else begin
      sxy_r <= SXY_W'(ax * ay);
      n_r   <= IW'(sxy_r * az);
      if (cfg_valid && cfg_ready) settle_r <= 2'd2;
      else if (settle_r != 2'd0) settle_r <= settle_r - 2'd1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_SIZE_X: size_x_r <= cfg_data[AXIS_W-1:0];
          CFG_SIZE_Y: size_y_r <= cfg_data[AXIS_W-1:0];
          CFG_SIZE_Z: size_z_r <= cfg_data[AXIS_W-1:0];
          CFG_FRAC:   frac_r   <= cfg_data[FRAC_W-1:0];
          CFG_PASSES: passes_r <= cfg_data[PASS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= '0;
      load_cnt_r  <= '0;
      fetch_cnt_r <= '0;
      ready_r     <= 1'b0;
      sel_r       <= 1'b0;
      p_v_r       <= 1'b0;
      nb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load a new result or drain the accepted one
      if (state_r == ST_FOUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_mask_r  <= hit_r && mq;
        out_last_r  <= last_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (is_load) begin
            if (ready_r) begin
              // new volume starts with this voxel
              ready_r     <= 1'b0;
              fetch_cnt_r <= '0;
              load_cnt_r  <= IW'(1);
              max_r       <= v_in;
            end else if (load_cnt_r < n_r) begin
              load_cnt_r <= load_cnt_r + IW'(1);
              if (v_in > max_r) max_r <= v_in;
            end
          end
        end
        ST_MUL: begin
          thr_idx_r <= '0;
          sel_r     <= 1'b0;
          p_v_r     <= 1'b0;
        end
        ST_THR: begin
          p_v_r   <= (thr_idx_r < n_r) && (thr_idx_r < MAXV);
          p_idx_r <= thr_idx_r;
          if (thr_idx_r < n_r) thr_idx_r <= thr_idx_r + IW'(1);
          if (thr_idx_r >= n_r && !p_v_r) begin
            pass_r <= '0;
            cidx_r <= '0;
            {x_r, y_r, z_r}    <= '0;
            {dx_r, dy_r, dz_r} <= '0;
            acc_r  <= 1'b1;
            nb_v_r <= 1'b0;
            if (passes_r == '0) ready_r <= 1'b1;
          end
        end
        ST_ER_RD: begin
          nb_v_r  <= nb_in;
          nb_rd_r <= nb_mem;
          if (nb_v_r) acc_r <= keep;
          if (dx_r == OFMAX) begin
            dx_r <= '0;
            if (dy_r == OFMAX) begin
              dy_r <= '0;
              dz_r <= (dz_r == OFMAX) ? '0 : dz_r + OFW'(1);
            end else begin
              dy_r <= dy_r + OFW'(1);
            end
          end else begin
            dx_r <= dx_r + OFW'(1);
          end
        end
        ST_ER_WR: begin
          acc_r  <= 1'b1;
          nb_v_r <= 1'b0;
          if (ctr_last) begin
            cidx_r <= '0;
            {x_r, y_r, z_r} <= '0;
            pass_r <= pass_r + PASS_W'(1);
            sel_r  <= !sel_r;
            if (pass_r + PASS_W'(1) == passes_r) ready_r <= 1'b1;
          end else begin
            cidx_r <= cidx_r + IW'(1);
            if ({1'b0, x_r} + 7'd1 == ax) begin
              x_r <= '0;
              if ({1'b0, y_r} + 7'd1 == ay) begin
                y_r <= '0;
                z_r <= z_r + POS_W'(1);
              end else begin
                y_r <= y_r + POS_W'(1);
              end
            end else begin
              x_r <= x_r + POS_W'(1);
            end
          end
        end
        ST_FRD: begin
          ready_r <= 1'b1;
          p_v_r   <= 1'b0;
          hit_r   <= (fetch_cnt_r < n_r) && (fetch_cnt_r < MAXV);
          last_r  <= (fetch_cnt_r < n_r) && (fetch_cnt_r + IW'(1) == n_r);
          if (fetch_cnt_r < n_r) fetch_cnt_r <= fetch_cnt_r + IW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) limit_r <= LW'(frac_r * max_r);
  end

  // voxel memory: write on load, read during threshold sweep
  always_ff @(posedge clk) begin
    if (is_load) begin
      if (ready_r) voxel_mem[0] <= v_in;
      else if (load_cnt_r < n_r && load_cnt_r < MAXV) voxel_mem[load_cnt_r[AW-1:0]] <= v_in;
    end
    if (v_re) vq_r <= voxel_mem[v_raddr];
  end

  // mask memories: threshold writes a, erosion rounds swap source and target
  always_ff @(posedge clk) begin
    if (state_r == ST_THR && p_v_r) begin
      mask_a[p_idx_r[AW-1:0]] <= ({vq_r, 16'b0} >= limit_r);
    end else if (state_r == ST_ER_WR && cidx_r < MAXV && sel_r) begin
      mask_a[cidx_r[AW-1:0]] <= keep;
    end
    if (m_re) qa_r <= mask_a[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ER_WR && cidx_r < MAXV && !sel_r) mask_b[cidx_r[AW-1:0]] <= keep;
    if (m_re) qb_r <= mask_b[m_raddr];
  end

  // checks
  a_out_from_fout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FOUT))
    else $error("result raised outside output state");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ER_WR |-> $past(state_r == ST_ER_RD))
    else $error("erosion write without neighbor reads");
  a_mul_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> $past(state_r == ST_IDLE) && !$past(ready_r))
    else $error("mask build started with mask already built");
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(state_r == ST_THR || state_r == ST_ER_WR || state_r == ST_FRD))
    else $error("mask marked ready outside build");

endmodule
